FILE: src/hrrn_ready_scheduler_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the HRRN ready scheduler
// Shared forms for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef HRRN_READY_SCHEDULER_DEFINES_SVH
`define HRRN_READY_SCHEDULER_DEFINES_SVH

// An implication checked at every clock edge outside reset.
`define HRRN_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define HRRN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/hrrn_pkg.sv
// ----------------------------------------------------------------------------
// HRRN scheduler package
// Shared widths, codes and the command record passed from front to back.
// ----------------------------------------------------------------------------
package hrrn_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int PID_W = 16;
  localparam int TIME_W = 32;
  localparam int ALPHA_W = 9;
  localparam int OP_W = 3;
  localparam int STATUS_W = 2;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd128;
  localparam logic [TIME_W-1:0] INIT_EST_RESET = 32'd10000;

  localparam logic [OP_W-1:0] OP_ADMIT = 3'd0;
  localparam logic [OP_W-1:0] OP_READY = 3'd1;
  localparam logic [OP_W-1:0] OP_DISPATCH = 3'd2;
  localparam logic [OP_W-1:0] OP_LEAVE = 3'd3;
  localparam logic [OP_W-1:0] OP_FINISH = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE_READY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

  localparam logic [0:0] REG_ALPHA = 1'b0;
  localparam logic [0:0] REG_INIT_EST = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [PID_W-1:0] proc_id;
    logic [TIME_W-1:0] now_ms;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PID_W-1:0] chosen_pid;
    logic [TIME_W-1:0] estimate_out;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MUL,
    S_CMP,
    S_EST,
    S_APPLY,
    S_OUT
  } state_t;

endpackage

FILE: src/hrrn_front.sv
// ----------------------------------------------------------------------------
// HRRN front end
// Accepts input items and holds them in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module hrrn_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  hrrn_pkg::cmd_t in_cmd,
  output logic          q_valid,
  input  logic          q_ready,
  output hrrn_pkg::cmd_t q_cmd
);

  hrrn_pkg::cmd_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready = (count != 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_cmd = mem[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: src/hrrn_engine.sv
// ----------------------------------------------------------------------------
// HRRN engine
// Applies one operation; walks the table a slot per cycle save ratio compares.
// ----------------------------------------------------------------------------
`include "hrrn_ready_scheduler_defines.svh"

module hrrn_engine #(
  parameter int NUM_SLOTS = hrrn_pkg::NUM_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  hrrn_pkg::cmd_t                q_cmd,
  input  logic [hrrn_pkg::ALPHA_W-1:0]  alpha_q8,
  input  logic [hrrn_pkg::TIME_W-1:0]   initial_estimate,
  output logic                          out_valid,
  input  logic                          out_ready,
  output hrrn_pkg::rsp_t                out_rsp
);

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int TW = hrrn_pkg::TIME_W;

  logic [NUM_SLOTS-1:0] slot_valid;
  logic [NUM_SLOTS-1:0] slot_ready;
  logic [hrrn_pkg::PID_W-1:0] slot_pid [NUM_SLOTS];
  logic [TW-1:0] ready_since [NUM_SLOTS];
  logic [TW-1:0] run_start [NUM_SLOTS];
  logic [TW-1:0] burst_estimate [NUM_SLOTS];

  hrrn_pkg::state_t state, state_next;
  hrrn_pkg::cmd_t cmd;
  logic [CNT_W-1:0] idx;
  logic [IDX_W-1:0] cur;
  logic found, free_found;
  logic [IDX_W-1:0] hit, free_idx;
  logic [TW-1:0] best_w, best_e, cand_w, cand_e;
  logic [2*TW-1:0] prod_l, prod_r;
  logic [8:0] a_sat;
  logic [TW-1:0] burst;
  logic [2*TW+1:0] est_sum;
  hrrn_pkg::rsp_t rsp;

  assign cur = idx[IDX_W-1:0];
  assign q_ready = (state == hrrn_pkg::S_IDLE);
  assign out_valid = (state == hrrn_pkg::S_OUT);
  assign out_rsp = rsp;
  assign a_sat = (alpha_q8 > 9'd256) ? 9'd256 : alpha_q8;
  assign burst = cmd.now_ms - run_start[hit];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hrrn_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      hrrn_pkg::S_IDLE: if (q_valid) state_next = hrrn_pkg::S_SCAN;
      hrrn_pkg::S_SCAN: begin
        if (idx == CNT_W'(NUM_SLOTS)) begin
          state_next = (cmd.op == hrrn_pkg::OP_LEAVE) ? hrrn_pkg::S_EST
                                                     : hrrn_pkg::S_APPLY;
        end else if (cmd.op == hrrn_pkg::OP_DISPATCH && slot_valid[cur] &&
                     slot_ready[cur] && found) begin
          state_next = hrrn_pkg::S_MUL;
        end
      end
      hrrn_pkg::S_MUL: state_next = hrrn_pkg::S_CMP;
      hrrn_pkg::S_CMP: state_next = hrrn_pkg::S_SCAN;
      hrrn_pkg::S_EST: state_next = hrrn_pkg::S_APPLY;
      hrrn_pkg::S_APPLY: state_next = hrrn_pkg::S_OUT;
      hrrn_pkg::S_OUT: if (out_ready) state_next = hrrn_pkg::S_IDLE;
      default: state_next = hrrn_pkg::S_IDLE;
    endcase
  end

  // Scan datapath: lookup, free search and the ratio compare share one index.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      slot_ready <= '0;
      found <= 1'b0;
      free_found <= 1'b0;
      idx <= '0;
    end else begin
      unique case (state)
        hrrn_pkg::S_IDLE: begin
          if (q_valid) begin
            cmd <= q_cmd;
            idx <= '0;
            found <= 1'b0;
            free_found <= 1'b0;
          end
        end
        hrrn_pkg::S_SCAN: begin
          if (idx != CNT_W'(NUM_SLOTS)) begin
            if (cmd.op == hrrn_pkg::OP_DISPATCH) begin
              if (slot_valid[cur] && slot_ready[cur]) begin
                cand_w <= cmd.now_ms - ready_since[cur];
                cand_e <= (burst_estimate[cur] == '0) ? TW'(1) : burst_estimate[cur];
                if (!found) begin
                  found <= 1'b1;
                  hit <= cur;
                  best_w <= cmd.now_ms - ready_since[cur];
                  best_e <= (burst_estimate[cur] == '0) ? TW'(1)
                                                        : burst_estimate[cur];
                  idx <= idx + 1'b1;
                end
              end else begin
                idx <= idx + 1'b1;
              end
            end else begin
              if (!found && slot_valid[cur] && slot_pid[cur] == cmd.proc_id) begin
                found <= 1'b1;
                hit <= cur;
              end
              if (!free_found && !slot_valid[cur]) begin
                free_found <= 1'b1;
                free_idx <= cur;
              end
              idx <= idx + 1'b1;
            end
          end
        end
        hrrn_pkg::S_MUL: begin
          prod_l <= cand_w * best_e;
          prod_r <= best_w * cand_e;
        end
        hrrn_pkg::S_CMP: begin
          if (prod_l > prod_r) begin
            hit <= cur;
            best_w <= cand_w;
            best_e <= cand_e;
          end
          idx <= idx + 1'b1;
        end
        hrrn_pkg::S_EST: begin
          est_sum <= ({{(2*TW-7){1'b0}}, a_sat} * {{(TW+2){1'b0}}, burst})
                   + ({{(2*TW-7){1'b0}}, 9'd256 - a_sat}
                      * {{(TW+2){1'b0}}, burst_estimate[hit]})
                   + (2*TW+2)'(128);
        end
        hrrn_pkg::S_APPLY: begin
          rsp.status <= hrrn_pkg::ST_OK;
          rsp.chosen_pid <= cmd.proc_id;
          rsp.estimate_out <= '0;
          case (cmd.op)
            hrrn_pkg::OP_ADMIT: begin
              if (found) begin
                rsp.estimate_out <= burst_estimate[hit];
              end else if (!free_found) begin
                rsp.status <= hrrn_pkg::ST_FULL;
              end else begin
                slot_valid[free_idx] <= 1'b1;
                slot_ready[free_idx] <= 1'b0;
                slot_pid[free_idx] <= cmd.proc_id;
                ready_since[free_idx] <= cmd.now_ms;
                run_start[free_idx] <= cmd.now_ms;
                burst_estimate[free_idx] <= initial_estimate;
                rsp.estimate_out <= initial_estimate;
              end
            end
            hrrn_pkg::OP_READY: begin
              if (!found) begin
                rsp.status <= hrrn_pkg::ST_UNKNOWN;
              end else begin
                slot_ready[hit] <= 1'b1;
                ready_since[hit] <= cmd.now_ms;
                rsp.estimate_out <= burst_estimate[hit];
              end
            end
            hrrn_pkg::OP_DISPATCH: begin
              if (!found) begin
                rsp.status <= hrrn_pkg::ST_NONE_READY;
                rsp.chosen_pid <= '0;
              end else begin
                slot_ready[hit] <= 1'b0;
                run_start[hit] <= cmd.now_ms;
                rsp.chosen_pid <= slot_pid[hit];
                rsp.estimate_out <= burst_estimate[hit];
              end
            end
            hrrn_pkg::OP_LEAVE: begin
              if (!found) begin
                rsp.status <= hrrn_pkg::ST_UNKNOWN;
              end else begin
                burst_estimate[hit] <= est_sum[TW+7:8];
                rsp.estimate_out <= est_sum[TW+7:8];
              end
            end
            hrrn_pkg::OP_FINISH: begin
              if (!found) begin
                rsp.status <= hrrn_pkg::ST_UNKNOWN;
              end else begin
                slot_valid[hit] <= 1'b0;
                slot_ready[hit] <= 1'b0;
                rsp.estimate_out <= burst_estimate[hit];
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  `HRRN_ASSERT_IMPL(a_ready_subset, 1'b1, (slot_ready & ~slot_valid) == '0,
    "ready slot that is not valid")
  `HRRN_ASSERT_NEXT(a_out_holds, out_valid && !out_ready,
    out_valid && $stable(out_rsp), "result changed while stalled")
  `HRRN_ASSERT_NEXT(a_apply_out, state == hrrn_pkg::S_APPLY, out_valid,
    "apply not followed by result")
  `HRRN_ASSERT_IMPL(a_idx_range, state == hrrn_pkg::S_MUL,
    idx < CNT_W'(NUM_SLOTS), "compare beyond table")

endmodule

FILE: src/hrrn_ready_scheduler.sv
// ----------------------------------------------------------------------------
// HRRN ready scheduler
// Highest-response-ratio-next process table with a queued command front end.
// ----------------------------------------------------------------------------
// Commands enter on the s_axis channel (op, proc_id, now_ms) and land in a
// two-entry queue, so a sender can post up to two items while the engine works.
// The engine takes one item at a time and walks the slot table one slot per
// cycle, apart from the compare pauses of a dispatch. Readies, admits and
// finishes pass through S_IDLE, S_SCAN over every slot, S_APPLY and S_OUT.
// A dispatch pauses the scan at each ready slot after the first, because
// each comparison of cross-multiplied ratios goes through a registered 32x32
// multiply pair in S_MUL and then a compare in S_CMP; the scan and that
// multiplier set the rate. A leave-cpu adds the S_EST state for the
// exponential-average multiply. One result per item leaves on m_axis from a
// held register; while the receiver stalls the engine waits, the queue still
// fills up to two items. Reset clears all valid and ready marks, restores
// alpha to 128 and the initial estimate to 10000; other slot fields are
// written on admission. The user must write configuration through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module hrrn_ready_scheduler #(
  parameter int NUM_SLOTS = hrrn_pkg::NUM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op [2:0], proc_id [18:3], now_ms [50:19], zero fill [55:51]
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status [1:0], chosen_pid [17:2], estimate_out [49:18], zero fill [55:50]
  output logic [55:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  hrrn_pkg::cmd_t in_cmd, q_cmd;
  hrrn_pkg::rsp_t rsp;
  logic q_valid, q_ready;
  logic [hrrn_pkg::ALPHA_W-1:0] alpha_q8;
  logic [hrrn_pkg::TIME_W-1:0] initial_estimate;

  assign in_cmd.op = s_axis_tdata[2:0];
  assign in_cmd.proc_id = s_axis_tdata[18:3];
  assign in_cmd.now_ms = s_axis_tdata[50:19];
  assign m_axis_tdata = {6'd0, rsp.estimate_out, rsp.chosen_pid, rsp.status};

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_q8 <= hrrn_pkg::ALPHA_RESET;
      initial_estimate <= hrrn_pkg::INIT_EST_RESET;
    end else if (cfg_we) begin
      if (cfg_index == hrrn_pkg::REG_ALPHA) begin
        alpha_q8 <= cfg_data[hrrn_pkg::ALPHA_W-1:0];
      end else begin
        initial_estimate <= cfg_data;
      end
    end
  end

  hrrn_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd(in_cmd),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  hrrn_engine #(.NUM_SLOTS(NUM_SLOTS)) u_engine (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .alpha_q8(alpha_q8), .initial_estimate(initial_estimate),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_rsp(rsp)
  );

endmodule
